// ===== rtl/mh_pkg.sv =====
// ----------------------------------------------------------------------------
// mh_pkg: shared types and constants of the magnetometer heading block
// Payload structs, register codes, datapath widths and the arctangent table
// used by the iterative CORDIC engine.
// ----------------------------------------------------------------------------
package mh_pkg;

  // Algorithm constants.
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int NSTEP  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int CNT_W  = $clog2(NSTEP);
  localparam int IDX_W  = 5;

  // Field widths.
  localparam int FLD_W  = 16;
  localparam int CAL_W  = 12;
  localparam int OFS_W  = 9;
  localparam int HEAD_W = 17;
  localparam int CFG_DW = 12;
  localparam int CFG_IW = 3;

  // Datapath widths.
  localparam int S_W  = CAL_W + 1;          // calibration span
  localparam int N_W  = 22;                 // centered, scaled reading
  localparam int P_W  = N_W + S_W;          // cross-scaled coordinate
  localparam int C_W  = P_W + 2;            // CORDIC vector with gain headroom
  localparam int Z_W  = 34;                 // angle in 2^-32 turn
  localparam int K_VAL = 360 << ANGLE_FRAC_BITS;
  localparam int K_W  = $clog2(K_VAL + 1) + 1;
  localparam int A_W  = (Z_W > N_W) ? Z_W : N_W;
  localparam int B_W  = (K_W > S_W) ? K_W : S_W;
  localparam int PR_W = A_W + B_W;
  localparam int OFF_W = OFS_W + ANGLE_FRAC_BITS;

  // Scaling factors of the calibration mapping.
  localparam int SCALE_IN   = 10;
  localparam int SCALE_LOW  = 100;
  localparam int SCALE_SPAN = 50;

  localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(1) << 31;

  // Reset values.
  localparam logic              ENABLE_RST   = 1'b1;
  localparam logic signed [CAL_W-1:0] CAL_X_LOW_RST  = -12'sd19;
  localparam logic signed [CAL_W-1:0] CAL_X_HIGH_RST = 12'sd23;
  localparam logic signed [CAL_W-1:0] CAL_Y_LOW_RST  = -12'sd49;
  localparam logic signed [CAL_W-1:0] CAL_Y_HIGH_RST = -12'sd9;
  localparam logic [OFS_W-1:0]        OFFSET_RST     = 9'd285;
  localparam logic signed [FLD_W-1:0] TRACK_MIN_RST  = 16'sd10000;
  localparam logic signed [FLD_W-1:0] TRACK_MAX_RST  = -16'sd10000;

  // Arctangent of 2^-i in 2^-32 turn, truncated.
  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  function automatic logic signed [Z_W-1:0] atan_at(input logic [IDX_W-1:0] idx);
    return Z_W'(ATAN_TURNS[idx]);
  endfunction

  typedef enum logic [CFG_IW-1:0] {
    CFG_ENABLE         = 3'd0,
    CFG_CAL_X_LOW      = 3'd1,
    CFG_CAL_X_HIGH     = 3'd2,
    CFG_CAL_Y_LOW      = 3'd3,
    CFG_CAL_Y_HIGH     = 3'd4,
    CFG_HEADING_OFFSET = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MULX,
    ST_MULY,
    ST_START,
    ST_ROT,
    ST_CONV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [FLD_W-1:0] field_x;
    logic signed [FLD_W-1:0] field_y;
  } in_t;

  typedef struct packed {
    logic signed [HEAD_W-1:0] heading;
    logic signed [FLD_W-1:0]  seen_x_min;
    logic signed [FLD_W-1:0]  seen_x_max;
    logic signed [FLD_W-1:0]  seen_y_min;
    logic signed [FLD_W-1:0]  seen_y_max;
    logic                     calib_error;
  } out_t;

  typedef struct packed {
    logic signed [FLD_W-1:0] x_min;
    logic signed [FLD_W-1:0] x_max;
    logic signed [FLD_W-1:0] y_min;
    logic signed [FLD_W-1:0] y_max;
  } track_t;

endpackage

// ===== rtl/mh_cordic.sv =====
// ----------------------------------------------------------------------------
// mh_cordic: iterative vectoring CORDIC
// Rotates (x, y) onto the positive X axis one micro-rotation per cycle and
// accumulates the angle in 2^-32 turn.
// ----------------------------------------------------------------------------
module mh_cordic (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [mh_pkg::C_W-1:0]   x_i,
  input  logic signed [mh_pkg::C_W-1:0]   y_i,
  output logic                            done_o,
  output logic signed [mh_pkg::Z_W-1:0]   angle_o
);
  import mh_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic signed [C_W-1:0]  x_q, x_d, y_q, y_d, dx, dy;
  logic signed [Z_W-1:0]  z_q, z_d, at;

  always_comb begin
    dx     = y_q >>> cnt_q;
    dy     = x_q >>> cnt_q;
    at     = atan_at(IDX_W'(cnt_q));
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (start_i) begin
      cnt_d = '0;
      if (x_i == '0 && y_i == '0) begin
        // Degenerate vector: the angle is zero and no rotation is run.
        z_d    = '0;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else if (x_i[C_W-1]) begin
        // Left half plane: turn by half a revolution first.
        z_d    = y_i[C_W-1] ? -Z_HALF : Z_HALF;
        x_d    = -x_i;
        y_d    = -y_i;
        busy_d = 1'b1;
      end else begin
        z_d    = '0;
        x_d    = x_i;
        y_d    = y_i;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (!y_q[C_W-1] && y_q != '0) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NSTEP - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o  = done_q;
  assign angle_o = z_q;

endmodule

// ===== rtl/mh_track.sv =====
// ----------------------------------------------------------------------------
// mh_track: running extremes of the raw readings
// Keeps the minimum and maximum of each axis over all samples marked by upd_i
// that have both axes nonzero.
// ----------------------------------------------------------------------------
module mh_track (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             upd_i,
  input  logic signed [mh_pkg::FLD_W-1:0]  x_i,
  input  logic signed [mh_pkg::FLD_W-1:0]  y_i,
  output mh_pkg::track_t                   track_o
);
  import mh_pkg::*;

  track_t track_q, track_d;

  always_comb begin
    track_d = track_q;
    if (upd_i && x_i != '0 && y_i != '0) begin
      if (x_i > track_q.x_max) track_d.x_max = x_i;
      if (x_i < track_q.x_min) track_d.x_min = x_i;
      if (y_i > track_q.y_max) track_d.y_max = y_i;
      if (y_i < track_q.y_min) track_d.y_min = y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q.x_min <= TRACK_MIN_RST;
      track_q.x_max <= TRACK_MAX_RST;
      track_q.y_min <= TRACK_MIN_RST;
      track_q.y_max <= TRACK_MAX_RST;
    end else begin
      track_q <= track_d;
    end
  end

  assign track_o = track_q;

endmodule

// ===== rtl/magnetometer_heading.sv =====
// ----------------------------------------------------------------------------
// magnetometer_heading: compass heading from one magnetometer X/Y sample
// Maps each axis through its calibration window and computes the heading as
// atan2 in 1/64 degree plus a whole-degree offset, with running extremes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_data_i) takes one X/Y
//   sample per transfer. The output channel (out_valid_o / out_ready_i /
//   out_data_o) returns the heading, the running extremes of both axes and
//   the calibration error flag. The configuration channel writes the enable,
//   the four calibration bounds and the heading offset; it is always ready
//   and must only be used while no sample is in flight.
//   A sample passes through scaling, the two cross multiplications, the
//   CORDIC setup, 16 CORDIC micro-rotations and the angle conversion
//   before the result is offered; the next sample is taken the cycle after
//   the result is registered. A bad calibration span skips the arithmetic
//   and goes straight to the result. The single shared multiplier and the
//   one-rotation-per-cycle CORDIC make these steps run one after another.
//   While disabled, samples are taken and dropped without a result.
//   If the receiver stalls, the finished result waits in the output
//   register while the next sample is already being worked on; a second
//   result waits in the final state until the register frees up.
//   Reset restores the default calibration and the extremes to +/-1000 uT.
// ----------------------------------------------------------------------------
module magnetometer_heading (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mh_pkg::in_t                   in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mh_pkg::out_t                  out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mh_pkg::CFG_IW-1:0]     cfg_index_i,
  input  logic [mh_pkg::CFG_DW-1:0]     cfg_data_i
);
  import mh_pkg::*;

  // Configuration registers.
  logic                     enable_q;
  logic signed [CAL_W-1:0]  cal_x_low_q, cal_x_high_q, cal_y_low_q, cal_y_high_q;
  logic [OFS_W-1:0]         heading_offset_q;

  // Sequencer and datapath registers.
  state_e                   state_q, state_d;
  logic signed [FLD_W-1:0]  x_q, y_q;
  logic                     err_q;
  logic signed [N_W-1:0]    nx_q, ny_q;
  logic signed [C_W-1:0]    px_q, py_q;
  logic signed [PR_W-1:0]   prod_q;
  logic                     out_valid_q;
  out_t                     out_q;

  logic                     in_xfer, cfg_xfer, load_out, rot_done, cord_start;
  logic signed [S_W-1:0]    sx, sy;
  logic signed [N_W-1:0]    nx_d, ny_d;
  logic signed [A_W-1:0]    mul_a;
  logic signed [B_W-1:0]    mul_b;
  logic signed [PR_W-1:0]   mul_p;
  logic signed [Z_W-1:0]    angle;
  logic [PR_W-1:0]          rnd;
  logic [OFF_W-1:0]         off_full;
  logic [HEAD_W-1:0]        off, head;
  track_t                   track;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q         <= ENABLE_RST;
      cal_x_low_q      <= CAL_X_LOW_RST;
      cal_x_high_q     <= CAL_X_HIGH_RST;
      cal_y_low_q      <= CAL_Y_LOW_RST;
      cal_y_high_q     <= CAL_Y_HIGH_RST;
      heading_offset_q <= OFFSET_RST;
    end else if (cfg_xfer) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ENABLE:         enable_q         <= cfg_data_i[0];
        CFG_CAL_X_LOW:      cal_x_low_q      <= cfg_data_i;
        CFG_CAL_X_HIGH:     cal_x_high_q     <= cfg_data_i;
        CFG_CAL_Y_LOW:      cal_y_low_q      <= cfg_data_i;
        CFG_CAL_Y_HIGH:     cal_y_high_q     <= cfg_data_i;
        CFG_HEADING_OFFSET: heading_offset_q <= cfg_data_i[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Calibration spans. A span of zero or less flags the sample as bad.
  assign sx = S_W'(cal_x_high_q) - S_W'(cal_x_low_q);
  assign sy = S_W'(cal_y_high_q) - S_W'(cal_y_low_q);

  // Centered readings scaled so that the mapped value is nx / sx exactly.
  assign nx_d = N_W'(x_q) * N_W'(SCALE_IN) - N_W'(cal_x_low_q) * N_W'(SCALE_LOW)
              - N_W'(sx) * N_W'(SCALE_SPAN);
  assign ny_d = N_W'(y_q) * N_W'(SCALE_IN) - N_W'(cal_y_low_q) * N_W'(SCALE_LOW)
              - N_W'(sy) * N_W'(SCALE_SPAN);

  // One multiplier serves both cross products and the angle conversion.
  always_comb begin
    case (state_q)
      ST_MULX: begin
        mul_a = A_W'(nx_q);
        mul_b = B_W'(sy);
      end
      ST_MULY: begin
        mul_a = A_W'(ny_q);
        mul_b = B_W'(sx);
      end
      default: begin
        mul_a = A_W'(angle);
        mul_b = B_W'(K_VAL);
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    cord_start = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && enable_q) begin
          if (sx[S_W-1] || sx == '0 || sy[S_W-1] || sy == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCALE;
          end
        end
      end
      ST_SCALE: state_d = ST_MULX;
      ST_MULX:  state_d = ST_MULY;
      ST_MULY:  state_d = ST_START;
      ST_START: begin
        cord_start = 1'b1;
        state_d    = ST_ROT;
      end
      ST_ROT: begin
        if (rot_done) state_d = ST_CONV;
      end
      ST_CONV: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers; each is written only in its own step.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q   <= in_data_i.field_x;
      y_q   <= in_data_i.field_y;
      err_q <= sx[S_W-1] || sx == '0 || sy[S_W-1] || sy == '0;
    end
    if (state_q == ST_SCALE) begin
      nx_q <= nx_d;
      ny_q <= ny_d;
    end
    if (state_q == ST_MULX) px_q <= C_W'(mul_p);
    if (state_q == ST_MULY) py_q <= C_W'(mul_p);
    if (state_q == ST_CONV) prod_q <= mul_p;
    if (load_out) begin
      out_q.heading     <= head;
      out_q.seen_x_min  <= track.x_min;
      out_q.seen_x_max  <= track.x_max;
      out_q.seen_y_min  <= track.y_min;
      out_q.seen_y_max  <= track.y_max;
      out_q.calib_error <= err_q;
    end
  end

  // Round the angle to output units (half up), then add the offset.
  assign rnd      = prod_q + (PR_W'(1) << 31);
  assign off_full = OFF_W'(heading_offset_q) << ANGLE_FRAC_BITS;
  assign off      = HEAD_W'(off_full);
  assign head     = err_q ? off : (rnd[32 +: HEAD_W] + off);

  mh_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .x_i     (px_q),
    .y_i     (py_q),
    .done_o  (rot_done),
    .angle_o (angle)
  );

  mh_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (in_xfer && enable_q),
    .x_i     (in_data_i.field_x),
    .y_i     (in_data_i.field_y),
    .track_o (track)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
